[design/sbie_pkg.sv]
// Package for the stop-bit integer encoder: widths, flag constants and the
// group sizing and group select functions. No dependencies.
package sbie_pkg;

   localparam int VALUE_W   = 64;
   localparam int GROUP_W   = 7;
   localparam int BYTE_W    = 8;
   localparam int MAX_BYTES = 10;
   localparam int COUNT_W   = $clog2(MAX_BYTES + 1);
   localparam int EXT_W     = GROUP_W * MAX_BYTES;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [GROUP_W-1:0] group_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam byte_type  STOP_FLAG  = 8'h80;
   localparam byte_type  SIGN_FLAG  = 8'h40;
   localparam value_type NO_TOP_BIT = {1'b0, {(VALUE_W-1){1'b1}}};

   // Fewest k with x >> (7k - drop_one) == 0, else the full byte count.
   function automatic count_type group_count(value_type x, logic drop_one);
      count_type k_sel;
      logic      found;
      k_sel = count_type'(MAX_BYTES);
      found = 1'b0;
      for (int k = 1; k < MAX_BYTES; k++) begin
         if (!found && ((x >> (GROUP_W * k - int'(drop_one))) == '0)) begin
            k_sel = count_type'(k);
            found = 1'b1;
         end
      end
      return k_sel;
   endfunction

   // Seven-bit group number g, counted from the least significant end.
   function automatic group_type group_at(value_type bits, count_type g);
      logic [EXT_W-1:0] ext;
      group_type        res;
      ext = EXT_W'(bits);
      res = '0;
      for (int i = 0; i < MAX_BYTES; i++) begin
         if (g == count_type'(i)) begin
            res = ext[GROUP_W*i +: GROUP_W];
         end
      end
      return res;
   endfunction

endpackage

[design/sbie_if.sv]
// Valid/ready channel interfaces for the encoder's request and response.
// Depends on sbie_pkg for field widths.
interface sbie_req_if import sbie_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type value;
   logic      is_signed;

   modport source (output valid, output value, output is_signed, input ready);
   modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface sbie_rsp_if import sbie_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

[design/stop_bit_integer_encoder_unit.sv]
// Stop-bit integer encoder: one 64-bit value in, 1 to 10 encoded bytes out.
// The item is registered in the holding register, and each byte is then registered
// in the output register. The response channel moves one byte per cycle while the
// sink is ready, and the next item loads as the last byte leaves the holding register.
// Reset (synchronous): clears the holding and output valid flags and the byte index.
// Depends on sbie_pkg and sbie_if.
module stop_bit_integer_encoder_unit import sbie_pkg::*; (
   input logic      clock,
   input logic      reset,
   sbie_req_if.sink   req_chan,
   sbie_rsp_if.source rsp_chan
);

   logic      hold_valid_ff, hold_valid_in;
   value_type value_ff, value_in;
   logic      signed_ff, signed_in;
   count_type idx_ff, idx_in;

   logic      rsp_valid_ff, rsp_valid_in;
   byte_type  rsp_byte_ff, rsp_byte_in;
   logic      rsp_last_ff, rsp_last_in;

   logic      neg;
   value_type mag;
   value_type bits;
   count_type n_bytes;
   logic      is_last;
   group_type grp;
   byte_type  cur_byte;
   logic      emit;
   logic      take;

   always_comb begin
      neg     = signed_ff & value_ff[VALUE_W-1];
      mag     = neg ? (~value_ff + value_type'(1)) : value_ff;
      n_bytes = group_count(signed_ff ? mag : value_ff, signed_ff);
      bits    = signed_ff ? (value_ff & NO_TOP_BIT) : value_ff;
      is_last = (idx_ff == n_bytes - count_type'(1));
      grp     = group_at(bits, n_bytes - count_type'(1) - idx_ff);
      cur_byte = byte_type'(grp);
      if (is_last) begin
         cur_byte = cur_byte | STOP_FLAG;
      end
      if (neg && (idx_ff == '0)) begin
         cur_byte = cur_byte | SIGN_FLAG;
      end
   end

   assign emit = hold_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !hold_valid_ff || (emit && is_last);
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      value_in      = value_ff;
      signed_in     = signed_ff;
      idx_in        = idx_ff;
      if (emit) begin
         idx_in = idx_ff + count_type'(1);
         if (is_last) begin
            hold_valid_in = 1'b0;
            idx_in        = '0;
         end
      end
      // load the next item as the current one drains
      if (take) begin
         hold_valid_in = 1'b1;
         value_in      = req_chan.value;
         signed_in     = req_chan.is_signed;
         idx_in        = '0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      signed_ff   <= signed_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.last     = rsp_last_ff;

endmodule

[design/sbie_checker.sv]
// Port-level checks on the encoder's response channel, bound to the top level.
// Depends on sbie_pkg and stop_bit_integer_encoder_unit.
module sbie_checker import sbie_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input byte_type rsp_out_byte,
   input logic     rsp_last
);

   count_type run_ff, run_in;

   // count bytes taken since the last end of an encoding
   always_comb begin
      run_in = run_ff;
      if (rsp_valid && rsp_ready) begin
         run_in = rsp_last ? '0 : run_ff + count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled item changed");

   a_stop_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_byte[BYTE_W-1] == rsp_last))
      else $error("stop flag disagrees with last");

   a_max_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (run_ff < count_type'(MAX_BYTES - 1)))
      else $error("encoding longer than ten bytes");

endmodule

bind stop_bit_integer_encoder_unit sbie_checker u_sbie_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_last     (rsp_chan.last)
);
